FILE: rtl/assert_macros.svh
// Assertion helpers for the box average filter RTL.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define AF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define AF_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define AF_ASSERT(lbl, prop, msg)
`define AF_NEVER(lbl, cond, msg)
`endif
`endif

FILE: rtl/bavg_pkg.sv
`default_nettype none
package bavg_pkg;

    localparam int unsigned MAX_RADIUS  = 15;
    localparam int unsigned STORE_DEPTH = 2 * MAX_RADIUS + 1;

    localparam int unsigned SAMPLE_W  = 8;
    localparam int unsigned SUM_W     = 13;
    localparam int unsigned CNT_W     = 5;
    localparam int unsigned RADIUS_W  = 4;
    localparam int unsigned MODE_W    = 2;
    localparam int unsigned SHIFT_W   = 5;
    localparam int unsigned CFG_W     = 5;
    localparam int unsigned CFG_IDX_W = 2;

    // Reciprocal of the window width for the division modes: ceil(2^RECIP_K / d).
    // With RECIP_K = 19 the product gives the exact quotient for any dividend
    // below 2^14.
    localparam int unsigned RECIP_K  = 19;
    localparam int unsigned RECIP_W  = 20;
    localparam int unsigned LAMBDA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_RADIUS      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NORM_MODE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RECIP_SHIFT = 2'd2;

    localparam logic [MODE_W-1:0] MODE_ROUND = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FLOOR = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RECIP = 2'd2;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                line_end;
    } item_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] average;
        logic                final_out;
    } result_t;

    typedef struct packed {
        logic load;
        logic move;
    } cell_ctrl_t;

    typedef struct packed {
        logic             valid;
        logic             final_flag;
        logic [SUM_W-1:0] sum;
    } em_t;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [RADIUS_W-1:0] radius;
        logic [SHIFT_W-1:0]  shift;
    } norm_cfg_t;

    typedef struct packed {
        logic adv;
        logic idle;
    } pipe_stat_t;

    typedef struct packed {
        logic             start;
        logic             step;
        logic [CNT_W-1:0] bit_idx;
    } recip_ctrl_t;

    function automatic logic [RECIP_W-1:0] recip_of(input logic [RADIUS_W-1:0] r);
        logic [RECIP_W-1:0] m;
        case (r)
            4'd0:    m = 20'd524288;
            4'd1:    m = 20'd174763;
            4'd2:    m = 20'd104858;
            4'd3:    m = 20'd74899;
            4'd4:    m = 20'd58255;
            4'd5:    m = 20'd47663;
            4'd6:    m = 20'd40330;
            4'd7:    m = 20'd34953;
            4'd8:    m = 20'd30841;
            4'd9:    m = 20'd27595;
            4'd10:   m = 20'd24967;
            4'd11:   m = 20'd22796;
            4'd12:   m = 20'd20972;
            4'd13:   m = 20'd19419;
            4'd14:   m = 20'd18079;
            default: m = 20'd16913;
        endcase
        return m;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/bavg_cell.sv
`default_nettype none
module bavg_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bavg_pkg::cell_ctrl_t          ctrl,
    input  logic [bavg_pkg::SAMPLE_W-1:0] load_value,
    input  logic [bavg_pkg::SAMPLE_W-1:0] prev_value,
    output logic [bavg_pkg::SAMPLE_W-1:0] value
);
    import bavg_pkg::*;

    logic [SAMPLE_W-1:0] value_reg;
    logic [SAMPLE_W-1:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.load)
        begin
            value_next = load_value;
        end
        else if (ctrl.move)
        begin
            value_next = prev_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
        end
        else
        begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule
`default_nettype wire

FILE: rtl/bavg_recip.sv
`default_nettype none
module bavg_recip (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bavg_pkg::recip_ctrl_t         ctrl,
    input  logic [bavg_pkg::SHIFT_W-1:0]  shift,
    input  logic [bavg_pkg::CNT_W-1:0]    divisor,
    output logic [bavg_pkg::LAMBDA_W-1:0] lambda
);
    import bavg_pkg::*;

    // Restoring division of 2^shift by the odd window width, one quotient bit
    // per step, most significant bit first.
    logic [CNT_W-1:0]    rem_reg;
    logic [CNT_W-1:0]    rem_next;
    logic [LAMBDA_W-1:0] lambda_reg;
    logic [LAMBDA_W-1:0] lambda_next;
    logic [CNT_W:0]      rem_wide;
    logic                take;

    always_comb
    begin
        rem_wide    = {rem_reg, (ctrl.bit_idx == shift)};
        take        = rem_wide >= {1'b0, divisor};
        rem_next    = rem_reg;
        lambda_next = lambda_reg;
        if (ctrl.start)
        begin
            rem_next = '0;
        end
        else if (ctrl.step)
        begin
            rem_next    = take ? CNT_W'(rem_wide - {1'b0, divisor}) : CNT_W'(rem_wide);
            lambda_next = {lambda_reg[LAMBDA_W-2:0], take};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
        end
        else
        begin
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lambda_reg <= lambda_next;
    end

    assign lambda = lambda_reg;

endmodule
`default_nettype wire

FILE: rtl/bavg_norm.sv
`default_nettype none
module bavg_norm (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bavg_pkg::em_t                 em,
    input  bavg_pkg::norm_cfg_t           cfg,
    input  logic [bavg_pkg::LAMBDA_W-1:0] lambda,
    output logic                          result_valid,
    input  logic                          result_ready,
    output bavg_pkg::result_t             result,
    output bavg_pkg::pipe_stat_t          stat
);
    import bavg_pkg::*;

    localparam int unsigned NUM_W  = SUM_W + 1;
    localparam int unsigned PROD_W = NUM_W + RECIP_W;
    localparam int unsigned HALF_W = LAMBDA_W / 2;
    localparam int unsigned PART_W = SUM_W + HALF_W;
    localparam int unsigned FULL_W = SUM_W + LAMBDA_W;

    logic                p1_valid_reg;
    logic                p1_final_reg;
    logic [SAMPLE_W-1:0] p1_div_reg;
    logic [PART_W-1:0]   p1_lo_reg;
    logic [PART_W-1:0]   p1_hi_reg;
    logic                out_valid_reg;
    result_t             out_reg;

    logic                adv;
    logic [NUM_W-1:0]    num;
    logic [PROD_W-1:0]   prod;
    logic [PART_W-1:0]   lo;
    logic [PART_W-1:0]   hi;
    logic [FULL_W-1:0]   full;
    logic [FULL_W-1:0]   shifted;
    logic [SAMPLE_W-1:0] avg;

    assign adv = !out_valid_reg || result_ready;

    // First stage: rounding offset and reciprocal multiply for the division
    // modes, and the fixed-point product over the 16-bit halves of lambda.
    always_comb
    begin
        num  = {1'b0, em.sum} + ((cfg.mode == MODE_ROUND) ? NUM_W'(cfg.radius) : '0);
        prod = PROD_W'(num) * PROD_W'(recip_of(cfg.radius));
        lo   = PART_W'(em.sum) * PART_W'(lambda[HALF_W-1:0]);
        hi   = PART_W'(em.sum) * PART_W'(lambda[LAMBDA_W-1:HALF_W]);
    end

    // Second stage: join the halves, drop the fraction bits and pick by mode.
    always_comb
    begin
        full    = {p1_hi_reg, HALF_W'(0)} + FULL_W'(p1_lo_reg);
        shifted = full >> cfg.shift;
        avg     = (cfg.mode == MODE_RECIP) ? shifted[SAMPLE_W-1:0] : p1_div_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p1_valid_reg  <= em.valid;
            out_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_final_reg      <= em.final_flag;
            p1_div_reg        <= prod[RECIP_K +: SAMPLE_W];
            p1_lo_reg         <= lo;
            p1_hi_reg         <= hi;
            out_reg.average   <= avg;
            out_reg.final_out <= p1_final_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;
    assign stat.adv     = adv;
    assign stat.idle    = !p1_valid_reg && !out_valid_reg;

endmodule
`default_nettype wire

FILE: rtl/box_average_filter.sv
// Channel   Handshake                   Payload
// item      item_valid / item_ready     item.sample, item.line_end
// result    result_valid / result_ready result.average, result.final_out
// config    cfg_we (no wait)            cfg_index, cfg_data
//
// Inside a line an item is taken every cycle unless a result stalls; its
// result, if any, passes the emit register and the first normalizer stage
// and leaves through the output register. An item with line_end and radius
// r > 0 holds item_ready low while the cell ring rotates past the stored samples
// and the pending outputs of the line are formed, at most one per cycle.
// After reset, and after each write to radius or recip_shift, a recompute pass
// (ring sweep plus 32-step reciprocal division) blocks items.
// A stalled result freezes the normalizer pipeline and holds item_ready low
// until the result is taken.
`default_nettype none
`include "assert_macros.svh"
module box_average_filter (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    output logic                           item_ready,
    input  bavg_pkg::item_t                item,
    output logic                           result_valid,
    input  logic                           result_ready,
    output bavg_pkg::result_t              result,
    input  logic                           cfg_we,
    input  logic [bavg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bavg_pkg::CFG_W-1:0]     cfg_data
);
    import bavg_pkg::*;

    // Configuration registers.
    logic [RADIUS_W-1:0] radius_reg;
    logic [MODE_W-1:0]   mode_reg;
    logic [SHIFT_W-1:0]  shift_reg;

    // Line state. Outside a recompute pass, sum_reg holds the current window
    // sum, from which an emitted result is formed.
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    sum_next;
    logic [SAMPLE_W-1:0] newest_reg;
    logic [SAMPLE_W-1:0] newest_next;
    logic [CNT_W-1:0]    seen_reg;
    logic [CNT_W-1:0]    seen_next;
    logic [RADIUS_W-1:0] span_reg;
    logic [RADIUS_W-1:0] span_next;
    logic                line_open_reg;
    logic                line_open_next;

    // Sequencing.
    logic                flush_busy_reg;
    logic                flush_busy_next;
    logic                pass_busy_reg;
    logic                pass_busy_next;
    logic                pass_pend_reg;
    logic                pass_pend_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;
    logic                em_valid_reg;
    logic                em_valid_next;
    logic                em_final_reg;
    logic                em_final_next;

    // Ring of sample cells, newest sample in cell 0 when the ring is at home.
    logic [SAMPLE_W-1:0] cell_q  [STORE_DEPTH];
    logic [SAMPLE_W-1:0] cell_in [STORE_DEPTH];
    logic [SAMPLE_W-1:0] head_in;
    cell_ctrl_t          cell_ctrl;

    logic [CNT_W-1:0]    two_r;
    logic [CNT_W-1:0]    width_d;
    logic [SAMPLE_W-1:0] tap;
    logic [SAMPLE_W-1:0] far;
    logic [CNT_W-1:0]    seen_now;
    logic                emit_ok;
    logic [CNT_W-1:0]    flush_j;
    logic [CNT_W-1:0]    flush_m;
    logic                flush_silent;
    logic                accept;
    logic                accept_end;
    logic                pass_start;
    logic                cfg_hit;

    em_t                 em_bus;
    norm_cfg_t           norm_cfg;
    pipe_stat_t          pipe_stat;
    recip_ctrl_t         recip_ctrl;
    logic [LAMBDA_W-1:0] lambda;

    assign two_r   = {radius_reg, 1'b0};
    assign width_d = {radius_reg, 1'b1};
    assign tap     = cell_q[STORE_DEPTH-1];
    assign far     = cell_q[two_r];

    assign item_ready = pipe_stat.adv && !flush_busy_reg && !pass_busy_reg && !pass_pend_reg;
    assign accept     = item_valid && item_ready;
    assign accept_end = accept && item.line_end;
    assign pass_start = pass_pend_reg && !pass_busy_reg && !flush_busy_reg
                        && !em_valid_reg && pipe_stat.idle;
    assign cfg_hit    = cfg_we && ((cfg_index == REG_RADIUS) || (cfg_index == REG_RECIP_SHIFT));

    always_comb
    begin
        seen_now     = line_open_reg ? seen_reg : '0;
        emit_ok      = seen_now >= CNT_W'(radius_reg);
        // While flushing, the cell at the ring's far end holds store entry j.
        flush_j      = cnt_reg - CNT_W'(1);
        flush_silent = flush_j > two_r;
        flush_m      = flush_j - CNT_W'(radius_reg) - CNT_W'(1);

        sum_next        = sum_reg;
        newest_next     = newest_reg;
        seen_next       = seen_reg;
        span_next       = span_reg;
        line_open_next  = line_open_reg;
        flush_busy_next = flush_busy_reg;
        pass_busy_next  = pass_busy_reg;
        cnt_next        = cnt_reg;
        em_valid_next   = em_valid_reg;
        em_final_next   = em_final_reg;
        cell_ctrl       = '0;
        head_in         = tap;
        pass_pend_next  = pass_pend_reg;

        if (pipe_stat.adv)
        begin
            em_valid_next = 1'b0;
            em_final_next = 1'b0;
        end

        if (accept)
        begin
            head_in     = item.sample;
            newest_next = item.sample;
            if (!line_open_reg)
            begin
                // The first sample of a line fills every cell: left border.
                cell_ctrl.load = 1'b1;
                sum_next       = SUM_W'(width_d) * SUM_W'(item.sample);
            end
            else
            begin
                cell_ctrl.move = 1'b1;
                sum_next       = sum_reg + SUM_W'(item.sample) - SUM_W'(far);
            end
            em_valid_next = emit_ok;
            em_final_next = item.line_end && (radius_reg == '0);
            if (item.line_end)
            begin
                line_open_next  = 1'b0;
                seen_next       = '0;
                span_next       = (seen_now < CNT_W'(radius_reg)) ?
                                  seen_now[RADIUS_W-1:0] : radius_reg;
                flush_busy_next = (radius_reg != '0);
                cnt_next        = CNT_W'(STORE_DEPTH);
            end
            else
            begin
                line_open_next = 1'b1;
                seen_next      = (seen_now == CNT_W'(STORE_DEPTH)) ? seen_now
                                                                   : seen_now + CNT_W'(1);
            end
        end
        else if (flush_busy_reg)
        begin
            // Walk the window toward the line end: each non-silent step drops
            // the oldest window sample and adds a copy of the last sample.
            if (flush_silent)
            begin
                cell_ctrl.move = 1'b1;
                cnt_next       = cnt_reg - CNT_W'(1);
            end
            else if (pipe_stat.adv)
            begin
                cell_ctrl.move = 1'b1;
                cnt_next       = cnt_reg - CNT_W'(1);
                sum_next       = sum_reg - SUM_W'(tap) + SUM_W'(newest_reg);
                em_valid_next  = flush_m <= CNT_W'(span_reg);
                em_final_next  = (flush_m == '0);
                if (flush_m == '0)
                begin
                    flush_busy_next = 1'b0;
                end
            end
        end
        else if (pass_busy_reg)
        begin
            // A full turn of the ring rebuilds the window sum for the
            // current radius while the reciprocal is divided out.
            if (cnt_reg != '0)
            begin
                cell_ctrl.move = 1'b1;
                if (cnt_reg <= width_d)
                begin
                    sum_next = sum_reg + SUM_W'(tap);
                end
                cnt_next = cnt_reg - CNT_W'(1);
            end
            else
            begin
                pass_busy_next = 1'b0;
            end
        end
        else if (pass_start)
        begin
            pass_busy_next = 1'b1;
            pass_pend_next = 1'b0;
            cnt_next       = CNT_W'(STORE_DEPTH);
            sum_next       = '0;
        end

        if (cfg_hit)
        begin
            pass_pend_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_W'(1);
            mode_reg   <= MODE_ROUND;
            shift_reg  <= SHIFT_W'(8);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_RADIUS:      radius_reg <= cfg_data[RADIUS_W-1:0];
                REG_NORM_MODE:   mode_reg   <= cfg_data[MODE_W-1:0];
                REG_RECIP_SHIFT: shift_reg  <= cfg_data[SHIFT_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg        <= '0;
            newest_reg     <= '0;
            seen_reg       <= '0;
            span_reg       <= '0;
            line_open_reg  <= 1'b0;
            flush_busy_reg <= 1'b0;
            pass_busy_reg  <= 1'b0;
            pass_pend_reg  <= 1'b1;
            cnt_reg        <= '0;
            em_valid_reg   <= 1'b0;
            em_final_reg   <= 1'b0;
        end
        else
        begin
            sum_reg        <= sum_next;
            newest_reg     <= newest_next;
            seen_reg       <= seen_next;
            span_reg       <= span_next;
            line_open_reg  <= line_open_next;
            flush_busy_reg <= flush_busy_next;
            pass_busy_reg  <= pass_busy_next;
            pass_pend_reg  <= pass_pend_next;
            cnt_reg        <= cnt_next;
            em_valid_reg   <= em_valid_next;
            em_final_reg   <= em_final_next;
        end
    end

    // Cell 0 takes the new sample on a shift, or the far end on a rotation.
    for (genvar i = 0; i < STORE_DEPTH; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            assign cell_in[i] = head_in;
        end
        else
        begin : g_body
            assign cell_in[i] = cell_q[i-1];
        end

        bavg_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (cell_ctrl),
            .load_value (item.sample),
            .prev_value (cell_in[i]),
            .value      (cell_q[i])
        );
    end

    assign recip_ctrl.start   = pass_start;
    assign recip_ctrl.step    = pass_busy_reg;
    assign recip_ctrl.bit_idx = cnt_reg;

    bavg_recip u_recip (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (recip_ctrl),
        .shift   (shift_reg),
        .divisor (width_d),
        .lambda  (lambda)
    );

    assign em_bus.valid      = em_valid_reg;
    assign em_bus.final_flag = em_final_reg;
    assign em_bus.sum        = sum_reg;
    assign norm_cfg.mode     = mode_reg;
    assign norm_cfg.radius   = radius_reg;
    assign norm_cfg.shift    = shift_reg;

    bavg_norm u_norm (
        .clk          (clk),
        .rst_n        (rst_n),
        .em           (em_bus),
        .cfg          (norm_cfg),
        .lambda       (lambda),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .stat         (pipe_stat)
    );

    `AF_NEVER(a_no_accept_busy, accept && (flush_busy_reg || pass_busy_reg), "item taken while busy")
    `AF_NEVER(a_no_emit_in_pass, pass_busy_reg && em_valid_reg, "result formed during recompute")
    `AF_ASSERT(a_flush_from_end, $rose(flush_busy_reg) |-> $past(accept_end), "flush without line end")
    `AF_ASSERT(a_final_ends_flush, (em_valid_reg && em_final_reg) |-> !flush_busy_reg, "final result before flush end")

endmodule
`default_nettype wire
